### sv/append_stream_suffix_max_defines.svh
// Assertion macros shared by the append_stream_suffix_max design files.
`ifndef APPEND_STREAM_SUFFIX_MAX_DEFINES_SVH
`define APPEND_STREAM_SUFFIX_MAX_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("append_stream_suffix_max: check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("append_stream_suffix_max: check failed");

`endif

### sv/assm_pkg.sv
// Shared item types and codes for the suffix-maximum store.
package assm_pkg;

	localparam int VAL_W     = 31;
	localparam int DIV_STEPS = 32;

	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	localparam logic ST_QUERY_ANSWER = 1'b0;
	localparam logic ST_APPEND_FULL  = 1'b1;

	typedef struct packed {
		logic             req_type;
		logic [VAL_W-1:0] operand;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] max_value;
		logic             status;
	} res_t;

endpackage

### sv/append_stream_suffix_max.sv
// Append-only value store with suffix-maximum queries over a range-max segment tree.
//
// After reset the block sweeps the tree memory to zero with busy high; configuration
// writes are taken at any time. An append item first takes the bit-serial modulo of
// (last answer + operand) by the modulus register, then writes the leaf and walks up
// the tree, each level writing a node, reading its sibling and moving to the parent
// with the larger of the two; an append into a full store returns its full status on
// the next cycle. A query walks the tree from both ends of the suffix, level by level,
// through the two read ports of the tree memory. The registered reads of the tree
// memory set the pace of both walks. A result is shown for exactly one cycle with done
// high and cannot be held off by the receiver.
`include "append_stream_suffix_max_defines.svh"

module append_stream_suffix_max #(
	parameter int CAPACITY = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  assm_pkg::req_t             req,
	output logic                       done,
	output assm_pkg::res_t             result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [assm_pkg::VAL_W-1:0] cfg_data
);
	import assm_pkg::*;

	localparam int DEPTH = 2 * CAPACITY;
	localparam int NW    = $clog2(DEPTH);
	localparam int AW    = NW + 1;
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int DCW   = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_UPW,
		S_UPR,
		S_QRD,
		S_QACC
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [VAL_W-1:0]   last_q;
	logic [VAL_W-1:0]   modulus_q;
	logic [NW-1:0]      clr_q;
	logic [31:0]        dvd_q;
	logic [VAL_W-1:0]   rem_q;
	logic [DCW-1:0]     div_cnt_q;
	logic [NW-1:0]      k_q;
	logic [VAL_W-1:0]   cur_q;
	logic [AW-1:0]      a_q;
	logic [AW-1:0]      b_q;
	logic               take0_q;
	logic               take1_q;
	logic               done_q;
	res_t               result_q;

	logic [VAL_W-1:0]   tree_mem [DEPTH];
	logic [VAL_W-1:0]   rd0_q;
	logic [VAL_W-1:0]   rd1_q;

	logic               mem_we;
	logic [NW-1:0]      mem_waddr;
	logic [VAL_W-1:0]   mem_wdata;
	logic [NW-1:0]      rd_addr0;
	logic [NW-1:0]      rd_addr1;

	logic               accept;
	logic               store_full;
	logic               full_shown;
	logic [31:0]        divisor;
	logic [31:0]        shifted;
	logic [VAL_W-1:0]   rem_next;
	logic [CW-1:0]      q_len;
	logic [CW-1:0]      q_lo;
	logic [AW-1:0]      b_m1;
	logic [VAL_W-1:0]   cand0;
	logic [VAL_W-1:0]   cand1;
	logic [VAL_W-1:0]   acc_next;
	logic [VAL_W-1:0]   up_max;

	assign busy       = (state_q != S_IDLE);
	assign cfg_ready  = 1'b1;
	assign done       = done_q;
	assign result     = result_q;
	assign accept     = start && !busy;
	assign store_full = (count_q == CW'(CAPACITY));
	assign full_shown = done && (result.status == ST_APPEND_FULL);

	// A zero modulus stands for 2^31, which wraps the sum to 31 bits.
	assign divisor  = (modulus_q == '0) ? 32'h8000_0000 : {1'b0, modulus_q};
	assign shifted  = {rem_q, dvd_q[31]};
	assign rem_next = (shifted >= divisor) ? VAL_W'(shifted - divisor) : shifted[VAL_W-1:0];

	assign q_len = (req.operand < {{(VAL_W-CW){1'b0}}, count_q}) ? req.operand[CW-1:0]
		: count_q;
	assign q_lo  = count_q - q_len;
	assign b_m1  = b_q - AW'(1);

	always_comb begin
		cand0    = take0_q ? rd0_q : '0;
		cand1    = take1_q ? rd1_q : '0;
		acc_next = cur_q;
		if (cand0 > acc_next)
			acc_next = cand0;
		if (cand1 > acc_next)
			acc_next = cand1;
		up_max = (rd0_q > cur_q) ? rd0_q : cur_q;
	end

	always_comb begin
		mem_we    = (state_q == S_CLEAR) || (state_q == S_UPW);
		mem_waddr = (state_q == S_CLEAR) ? clr_q : k_q;
		mem_wdata = (state_q == S_CLEAR) ? '0 : cur_q;
		rd_addr0  = (state_q == S_UPW) ? (k_q ^ NW'(1)) : a_q[NW-1:0];
		rd_addr1  = b_m1[NW-1:0];
	end

	// Tree memory: one write port and two registered read ports.
	always_ff @(posedge clk) begin
		if (mem_we)
			tree_mem[mem_waddr] <= mem_wdata;
		rd0_q <= tree_mem[rd_addr0];
		rd1_q <= tree_mem[rd_addr1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			count_q   <= '0;
			last_q    <= '0;
			modulus_q <= {VAL_W{1'b1}};
			clr_q     <= '0;
			done_q    <= 1'b0;
			dvd_q     <= '0;
			rem_q     <= '0;
			div_cnt_q <= '0;
			k_q       <= '0;
			cur_q     <= '0;
			a_q       <= '0;
			b_q       <= '0;
			take0_q   <= 1'b0;
			take1_q   <= 1'b0;
			result_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready)
				modulus_q <= cfg_data;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == NW'(DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						if (req.req_type == REQ_QUERY) begin
							a_q     <= AW'(q_lo) + AW'(CAPACITY);
							b_q     <= AW'(count_q) + AW'(CAPACITY);
							cur_q   <= '0;
							state_q <= S_QRD;
						end else if (store_full) begin
							done_q             <= 1'b1;
							result_q.max_value <= '0;
							result_q.status    <= ST_APPEND_FULL;
						end else begin
							dvd_q     <= {1'b0, last_q} + {1'b0, req.operand};
							rem_q     <= '0;
							div_cnt_q <= '0;
							state_q   <= S_DIV;
						end
					end
				end
				S_DIV: begin
					rem_q     <= rem_next;
					dvd_q     <= {dvd_q[30:0], 1'b0};
					div_cnt_q <= div_cnt_q + DCW'(1);
					if (div_cnt_q == DCW'(DIV_STEPS - 1)) begin
						cur_q   <= rem_next;
						k_q     <= NW'(CAPACITY) + NW'(count_q);
						count_q <= count_q + CW'(1);
						state_q <= S_UPW;
					end
				end
				S_UPW: begin
					// The node at k_q is written now; the root ends the walk.
					if (k_q == NW'(1))
						state_q <= S_IDLE;
					else
						state_q <= S_UPR;
				end
				S_UPR: begin
					cur_q   <= up_max;
					k_q     <= k_q >> 1;
					state_q <= S_UPW;
				end
				S_QRD: begin
					if (a_q < b_q) begin
						take0_q <= a_q[0];
						take1_q <= b_q[0];
						a_q     <= (a_q + AW'(a_q[0])) >> 1;
						b_q     <= b_q >> 1;
						state_q <= S_QACC;
					end else begin
						last_q             <= cur_q;
						done_q             <= 1'b1;
						result_q.max_value <= cur_q;
						result_q.status    <= ST_QUERY_ANSWER;
						state_q            <= S_IDLE;
					end
				end
				S_QACC: begin
					cur_q   <= acc_next;
					state_q <= S_QRD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSM_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(CAPACITY))
	`ASSM_ASSERT_NEXT(a_query_walk, accept && (req.req_type == REQ_QUERY), state_q == S_QRD)
	`ASSM_ASSERT_NOW(a_full_result, full_shown, store_full && (result.max_value == '0))
	`ASSM_ASSERT_NOW(a_walk_order, state_q == S_QACC, a_q <= b_q)

endmodule
